FILE: sv/assert_macros.svh
// Assertion helpers shared by the scorer RTL.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: sv/bcls_pkg.sv
// ---------------------------------------------------------------------------
// bcls_pkg
// Shared types, defaults and helpers of the boosted cascade LUT scorer.
// ---------------------------------------------------------------------------
package bcls_pkg;

    localparam int DEF_NUM_BINS   = 256;
    localparam int DEF_GROUP_SIZE = 10;
    localparam int DEF_MAX_STAGES = 256;

    localparam int          TABLE_STAGES  = 256;
    localparam logic [8:0]  STAGES_RESET  = 9'd150;
    localparam int          RECIP_SHIFT   = 16;

    typedef enum logic [1:0] {
        CMD_WEIGHT    = 2'd0,
        CMD_THRESHOLD = 2'd1,
        CMD_START     = 2'd2,
        CMD_FEATURE   = 2'd3
    } t_cmd;

    typedef enum logic [1:0] {
        CFG_STAGES    = 2'd0,
        CFG_GATE_EN   = 2'd1,
        CFG_DEV_THR   = 2'd2
    } t_cfg_reg;

    // Control beat handed from the front end to the scoring stage.
    typedef struct packed {
        logic       valid;
        logic       start;
        logic       feat;
        logic       last;
        logic       bound;
        logic [8:0] count;
    } t_s1;

    typedef struct packed {
        logic              face;
        logic signed [31:0] score;
        logic [8:0]        count;
    } t_res;

    // Stage count clamped to the table and rounded down to whole groups.
    // Division by the group size is a multiply by its scaled reciprocal.
    function automatic logic [8:0] eff_count(
        input logic [8:0]  n,
        input logic [16:0] recip,
        input logic [6:0]  grp,
        input logic [8:0]  tabs
    );
        logic [8:0]  c;
        logic [25:0] p;
        logic [8:0]  q;
        logic [15:0] m;
        c = (n > tabs) ? tabs : n;
        p = {17'd0, c} * {9'd0, recip};
        q = p[RECIP_SHIFT+8:RECIP_SHIFT];
        m = {7'd0, q} * {9'd0, grp};
        return m[8:0];
    endfunction

endpackage

FILE: sv/bcls_ram.sv
// ---------------------------------------------------------------------------
// bcls_ram
// Simple dual-port RAM, one write port, one read port with registered data.
// ---------------------------------------------------------------------------
module bcls_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 256
) (
    input  logic                     i_clk,
    input  logic                     i_we,
    input  logic [$clog2(DEPTH)-1:0] i_waddr,
    input  logic [WIDTH-1:0]         i_wdata,
    input  logic                     i_re,
    input  logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];
    logic [WIDTH-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            r_rdata <= r_mem[i_raddr];
        end
    end

    assign o_rdata = r_rdata;

endmodule

FILE: sv/bcls_front.sv
// ---------------------------------------------------------------------------
// bcls_front
// Command decode, table write and read addressing, stage and group tracking.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bcls_front #(
    parameter int NUM_BINS   = bcls_pkg::DEF_NUM_BINS,
    parameter int GROUP_SIZE = bcls_pkg::DEF_GROUP_SIZE,
    parameter int MAX_STAGES = bcls_pkg::DEF_MAX_STAGES,
    localparam int TAB_STG   = (MAX_STAGES < bcls_pkg::TABLE_STAGES) ?
                               MAX_STAGES : bcls_pkg::TABLE_STAGES,
    localparam int STG_W     = $clog2(TAB_STG),
    localparam int BIN_W     = $clog2(NUM_BINS),
    localparam int WADDR_W   = STG_W + BIN_W
) (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  logic                 i_accept,
    input  logic [1:0]           i_command,
    input  logic [7:0]           i_stage_index,
    input  logic [7:0]           i_bin_index,
    input  logic [7:0]           i_feature_value,
    input  logic [31:0]          i_window_deviation,
    input  logic [8:0]           i_eff,
    output logic                 o_w_we,
    output logic [WADDR_W-1:0]   o_w_waddr,
    output logic                 o_w_re,
    output logic [WADDR_W-1:0]   o_w_raddr,
    output logic                 o_t_we,
    output logic [STG_W-1:0]     o_t_waddr,
    output logic                 o_t_re,
    output logic [STG_W-1:0]     o_t_raddr,
    output bcls_pkg::t_s1        o_s1,
    output logic [31:0]          o_dev
);

    localparam int GRP_W = (GROUP_SIZE > 1) ? $clog2(GROUP_SIZE) : 1;

    bcls_pkg::t_cmd   cmd;
    logic             stage_ok;
    logic             bin_ok;
    logic             feat_big;
    logic [BIN_W-1:0] feat_bin;
    logic [8:0]       stage_inc;
    logic             bound;

    logic             r_active, n_active;
    logic [8:0]       r_stage,  n_stage;
    logic [GRP_W-1:0] r_grp,    n_grp;
    bcls_pkg::t_s1    r_s1,     n_s1;
    logic [31:0]      r_dev;

    assign cmd      = bcls_pkg::t_cmd'(i_command);
    assign stage_ok = {1'b0, i_stage_index} < 9'(TAB_STG);
    assign bin_ok   = {1'b0, i_bin_index} < 9'(NUM_BINS);
    assign feat_big = {1'b0, i_feature_value} >= 9'(NUM_BINS);
    assign feat_bin = feat_big ? BIN_W'(NUM_BINS - 1) : i_feature_value[BIN_W-1:0];
    assign stage_inc = r_stage + 9'd1;
    assign bound     = r_grp == GRP_W'(GROUP_SIZE - 1);

    // Table writes land at their own beat; later reads see them.
    assign o_w_we    = i_accept && (cmd == bcls_pkg::CMD_WEIGHT) && stage_ok && bin_ok;
    assign o_w_waddr = {i_stage_index[STG_W-1:0], i_bin_index[BIN_W-1:0]};
    assign o_t_we    = i_accept && (cmd == bcls_pkg::CMD_THRESHOLD) && stage_ok;
    assign o_t_waddr = i_stage_index[STG_W-1:0];

    assign o_w_re    = i_accept && (cmd == bcls_pkg::CMD_FEATURE);
    assign o_w_raddr = {r_stage[STG_W-1:0], feat_bin};
    assign o_t_re    = o_w_re;
    assign o_t_raddr = r_stage[STG_W-1:0];

    always_comb begin
        n_active = r_active;
        n_stage  = r_stage;
        n_grp    = r_grp;
        n_s1     = '0;
        if (i_accept) begin
            case (cmd)
                bcls_pkg::CMD_START: begin
                    n_stage      = 9'd0;
                    n_grp        = '0;
                    n_active     = i_eff != 9'd0;
                    n_s1.valid   = 1'b1;
                    n_s1.start   = 1'b1;
                    n_s1.last    = i_eff == 9'd0;
                end
                bcls_pkg::CMD_FEATURE: begin
                    if (r_active) begin
                        n_stage    = stage_inc;
                        n_grp      = bound ? '0 : r_grp + GRP_W'(1);
                        n_active   = stage_inc < i_eff;
                        n_s1.valid = 1'b1;
                        n_s1.feat  = 1'b1;
                        n_s1.last  = stage_inc >= i_eff;
                        n_s1.bound = bound;
                        n_s1.count = stage_inc;
                    end
                end
                default: begin
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_active <= 1'b0;
            r_stage  <= 9'd0;
            r_grp    <= '0;
            r_s1     <= '0;
        end else begin
            r_active <= n_active;
            r_stage  <= n_stage;
            r_grp    <= n_grp;
            r_s1     <= n_s1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_accept && (cmd == bcls_pkg::CMD_START)) begin
            r_dev <= i_window_deviation;
        end
    end

    assign o_s1  = r_s1;
    assign o_dev = r_dev;

    `ASSERT_IMPLY(a_grp_range, i_clk, i_rst_n, 1'b1, r_grp <= GRP_W'(GROUP_SIZE - 1),
        "group counter out of range")
    `ASSERT_NEXT(a_start_clears, i_clk, i_rst_n, i_accept && (cmd == bcls_pkg::CMD_START),
        (r_stage == 9'd0) && (r_grp == '0) && r_s1.start, "start did not clear the stage count")

endmodule

FILE: sv/bcls_score.sv
// ---------------------------------------------------------------------------
// bcls_score
// Running-score accumulate, group threshold check, decision and output buffer.
// ---------------------------------------------------------------------------
`include "assert_macros.svh"

module bcls_score (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  bcls_pkg::t_s1      i_s1,
    input  logic signed [15:0] i_weight,
    input  logic signed [31:0] i_thresh,
    input  logic [31:0]        i_dev,
    input  logic               i_gate_en,
    input  logic [31:0]        i_dev_thr,
    output logic               o_room,
    output logic               o_valid,
    input  logic               i_ready,
    output bcls_pkg::t_res     o_res
);

    logic signed [32:0] sum_wide;
    logic signed [31:0] sum_sat;
    logic               gate_ok;
    logic               reject;
    logic               emit;
    bcls_pkg::t_res     res;

    logic               r_done,  n_done;
    logic signed [31:0] r_score, n_score;
    logic               r_ov,    n_ov;
    logic               r_sv,    n_sv;
    bcls_pkg::t_res     r_o,     n_o;
    bcls_pkg::t_res     r_s,     n_s;

    assign sum_wide = {r_score[31], r_score} + 33'(i_weight);
    always_comb begin
        if (sum_wide[32] != sum_wide[31]) begin
            sum_sat = sum_wide[32] ? 32'sh8000_0000 : 32'sh7FFF_FFFF;
        end else begin
            sum_sat = sum_wide[31:0];
        end
    end

    assign gate_ok = !i_gate_en || (i_dev > i_dev_thr);
    assign reject  = i_s1.bound && (sum_sat < i_thresh);

    always_comb begin
        n_done    = r_done;
        n_score   = r_score;
        emit      = 1'b0;
        res.face  = 1'b0;
        res.score = r_score;
        res.count = i_s1.count;
        if (i_s1.valid && i_s1.start) begin
            n_score   = '0;
            n_done    = i_s1.last;
            emit      = i_s1.last;
            res.face  = gate_ok;
            res.score = '0;
        end else if (i_s1.valid && i_s1.feat && !r_done) begin
            n_score   = sum_sat;
            emit      = reject || i_s1.last;
            n_done    = emit;
            res.face  = !reject && gate_ok;
            res.score = sum_sat;
        end
    end

    // Output register plus skid slot; drain first, then take the new result.
    always_comb begin
        n_ov = r_ov;
        n_sv = r_sv;
        n_o  = r_o;
        n_s  = r_s;
        if (r_ov && i_ready) begin
            if (r_sv) begin
                n_o  = r_s;
                n_sv = 1'b0;
            end else begin
                n_ov = 1'b0;
            end
        end
        if (emit) begin
            if (!n_ov) begin
                n_ov = 1'b1;
                n_o  = res;
            end else begin
                n_sv = 1'b1;
                n_s  = res;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_done  <= 1'b1;
            r_score <= '0;
            r_ov    <= 1'b0;
            r_sv    <= 1'b0;
        end else begin
            r_done  <= n_done;
            r_score <= n_score;
            r_ov    <= n_ov;
            r_sv    <= n_sv;
        end
    end

    always_ff @(posedge i_clk) begin
        r_o <= n_o;
        r_s <= n_s;
    end

    // Hold input while the beat in flight might find no slot.
    assign o_room  = !r_sv && !(i_s1.valid && r_ov && !i_ready);
    assign o_valid = r_ov;
    assign o_res   = r_o;

    `ASSERT_IMPLY(a_skid_order, i_clk, i_rst_n, r_sv, r_ov, "skid slot full with output empty")
    `ASSERT_IMPLY(a_no_overflow, i_clk, i_rst_n, emit && r_sv, r_ov && i_ready,
        "result arrived with no free slot")

endmodule

FILE: sv/boosted_cascade_lut_scorer.sv
// ---------------------------------------------------------------------------
// boosted_cascade_lut_scorer
// Scores detection windows through a boosted cascade of LUT weak classifiers.
// ---------------------------------------------------------------------------
// A decision passes the front-end register, then the output or skid register.
// One command beat per cycle while input ready is high; the weight and threshold
// RAM reads and the score add/compare sit in separate pipeline stages.
// Input ready drops only while the skid slot is full, or the output register
// is full and stalled with a beat in flight. Reset clears control state only;
// weight and threshold tables hold garbage until written; no clearing pass runs.
module boosted_cascade_lut_scorer #(
    parameter int NUM_BINS   = bcls_pkg::DEF_NUM_BINS,
    parameter int GROUP_SIZE = bcls_pkg::DEF_GROUP_SIZE,
    parameter int MAX_STAGES = bcls_pkg::DEF_MAX_STAGES
) (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_in_valid,
    output logic               o_in_ready,
    input  logic [1:0]         i_command,
    input  logic [7:0]         i_stage_index,
    input  logic [7:0]         i_bin_index,
    input  logic signed [15:0] i_weight_value,
    input  logic signed [31:0] i_threshold_value,
    input  logic [31:0]        i_window_deviation,
    input  logic [7:0]         i_feature_value,
    output logic               o_out_valid,
    input  logic               i_out_ready,
    output logic               o_is_face,
    output logic signed [31:0] o_score,
    output logic [8:0]         o_stages_done,
    input  logic               i_cfg_valid,
    output logic               o_cfg_ready,
    input  logic [1:0]         i_cfg_index,
    input  logic [31:0]        i_cfg_data
);

    localparam int TAB_STG = (MAX_STAGES < bcls_pkg::TABLE_STAGES) ?
                             MAX_STAGES : bcls_pkg::TABLE_STAGES;
    localparam int STG_W   = $clog2(TAB_STG);
    localparam int BIN_W   = $clog2(NUM_BINS);
    localparam int WADDR_W = STG_W + BIN_W;
    localparam int W_DEPTH = TAB_STG * (2 ** BIN_W);
    localparam int RECIP   = ((2 ** bcls_pkg::RECIP_SHIFT) + GROUP_SIZE - 1) / GROUP_SIZE;

    logic               accept;
    logic               cfg_we;
    bcls_pkg::t_cfg_reg cfg_reg;

    logic [8:0]   r_eff;
    logic         r_gate_en;
    logic [31:0]  r_dev_thr;

    logic               w_we, w_re, t_we, t_re;
    logic [WADDR_W-1:0] w_waddr, w_raddr;
    logic [STG_W-1:0]   t_waddr, t_raddr;
    logic [15:0]        w_rdata;
    logic [31:0]        t_rdata;
    bcls_pkg::t_s1      s1;
    logic [31:0]        dev;
    logic               room;
    bcls_pkg::t_res     res;

    assign accept      = i_in_valid && o_in_ready;
    assign o_in_ready  = room;
    assign o_cfg_ready = 1'b1;
    assign cfg_we      = i_cfg_valid && o_cfg_ready;
    assign cfg_reg     = bcls_pkg::t_cfg_reg'(i_cfg_index);

    // Keep the stage count already clamped and rounded to whole groups.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_eff     <= bcls_pkg::eff_count(bcls_pkg::STAGES_RESET, 17'(RECIP),
                                             7'(GROUP_SIZE), 9'(TAB_STG));
            r_gate_en <= 1'b1;
            r_dev_thr <= '0;
        end else if (cfg_we) begin
            case (cfg_reg)
                bcls_pkg::CFG_STAGES: begin
                    r_eff <= bcls_pkg::eff_count(i_cfg_data[8:0], 17'(RECIP),
                                                 7'(GROUP_SIZE), 9'(TAB_STG));
                end
                bcls_pkg::CFG_GATE_EN: begin
                    r_gate_en <= i_cfg_data[0];
                end
                bcls_pkg::CFG_DEV_THR: begin
                    r_dev_thr <= i_cfg_data;
                end
                default: begin
                end
            endcase
        end
    end

    bcls_front #(
        .NUM_BINS   (NUM_BINS),
        .GROUP_SIZE (GROUP_SIZE),
        .MAX_STAGES (MAX_STAGES)
    ) u_front (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_accept           (accept),
        .i_command          (i_command),
        .i_stage_index      (i_stage_index),
        .i_bin_index        (i_bin_index),
        .i_feature_value    (i_feature_value),
        .i_window_deviation (i_window_deviation),
        .i_eff              (r_eff),
        .o_w_we             (w_we),
        .o_w_waddr          (w_waddr),
        .o_w_re             (w_re),
        .o_w_raddr          (w_raddr),
        .o_t_we             (t_we),
        .o_t_waddr          (t_waddr),
        .o_t_re             (t_re),
        .o_t_raddr          (t_raddr),
        .o_s1               (s1),
        .o_dev              (dev)
    );

    bcls_ram #(
        .WIDTH (16),
        .DEPTH (W_DEPTH)
    ) u_weight_ram (
        .i_clk   (i_clk),
        .i_we    (w_we),
        .i_waddr (w_waddr),
        .i_wdata (i_weight_value),
        .i_re    (w_re),
        .i_raddr (w_raddr),
        .o_rdata (w_rdata)
    );

    bcls_ram #(
        .WIDTH (32),
        .DEPTH (TAB_STG)
    ) u_thresh_ram (
        .i_clk   (i_clk),
        .i_we    (t_we),
        .i_waddr (t_waddr),
        .i_wdata (i_threshold_value),
        .i_re    (t_re),
        .i_raddr (t_raddr),
        .o_rdata (t_rdata)
    );

    bcls_score u_score (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_s1      (s1),
        .i_weight  (w_rdata),
        .i_thresh  (t_rdata),
        .i_dev     (dev),
        .i_gate_en (r_gate_en),
        .i_dev_thr (r_dev_thr),
        .o_room    (room),
        .o_valid   (o_out_valid),
        .i_ready   (i_out_ready),
        .o_res     (res)
    );

    assign o_is_face     = res.face;
    assign o_score       = res.score;
    assign o_stages_done = res.count;

endmodule

FILE: bench/tb.sv
// ----------------------------------------------------------------------------
// Boosted cascade scorer testbench
// Drives command beats (table writes, window starts, feature codes) and
// register writes into the scorer, and keeps its own copy of the tables and
// window state to predict every decision. Each decision is checked field by
// field against the oldest pending prediction. Both handshakes idle and stall
// at random.
// ----------------------------------------------------------------------------
module tb;
    timeunit 1ns;
    timeprecision 1ps;

    localparam int RESET_CYCLES   = 10;
    localparam int SETTLE_CYCLES  = 4;
    localparam int WATCHDOG_LIMIT = 2000;
    localparam int ITEM_TARGET    = 1600;
    localparam int MAX_REPORTS    = 40;

    localparam longint SCORE_MAX = 64'sd2147483647;
    localparam longint SCORE_MIN = -64'sd2147483648;

    typedef enum {WIN_IDLE, WIN_ACTIVE, WIN_DONE} t_win_state;

    typedef struct {
        bcls_pkg::t_cmd     cmd;
        logic [7:0]         stage;
        logic [7:0]         bin;
        logic signed [15:0] weight;
        logic signed [31:0] thr;
        logic [31:0]        dev;
        logic [7:0]         feat;
    } t_scorer_cmd;

    logic               clk = 1'b0;
    logic               rst_n = 1'b0;
    logic               in_valid = 1'b0;
    logic [1:0]         in_command = '0;
    logic [7:0]         in_stage = '0;
    logic [7:0]         in_bin = '0;
    logic signed [15:0] in_weight = '0;
    logic signed [31:0] in_thr = '0;
    logic [31:0]        in_dev = '0;
    logic [7:0]         in_feat = '0;
    logic               out_ready = 1'b0;
    logic               cfg_valid = 1'b0;
    logic [1:0]         cfg_index = '0;
    logic [31:0]        cfg_data = '0;

    wire                o_in_ready;
    wire                o_out_valid;
    wire                o_is_face;
    wire signed [31:0]  o_score;
    wire [8:0]          o_stages_done;
    wire                o_cfg_ready;

    boosted_cascade_lut_scorer #(
        .NUM_BINS   (bcls_pkg::DEF_NUM_BINS),
        .GROUP_SIZE (bcls_pkg::DEF_GROUP_SIZE),
        .MAX_STAGES (bcls_pkg::DEF_MAX_STAGES)
    ) dut (
        .i_clk              (clk),
        .i_rst_n            (rst_n),
        .i_in_valid         (in_valid),
        .o_in_ready         (o_in_ready),
        .i_command          (in_command),
        .i_stage_index      (in_stage),
        .i_bin_index        (in_bin),
        .i_weight_value     (in_weight),
        .i_threshold_value  (in_thr),
        .i_window_deviation (in_dev),
        .i_feature_value    (in_feat),
        .o_out_valid        (o_out_valid),
        .i_out_ready        (out_ready),
        .o_is_face          (o_is_face),
        .o_score            (o_score),
        .o_stages_done      (o_stages_done),
        .i_cfg_valid        (cfg_valid),
        .o_cfg_ready        (o_cfg_ready),
        .i_cfg_index        (cfg_index),
        .i_cfg_data         (cfg_data)
    );

    // Predicted scorer state
    logic signed [15:0] weight_mem [bcls_pkg::TABLE_STAGES][bcls_pkg::DEF_NUM_BINS];
    bit                 weight_set [bcls_pkg::TABLE_STAGES][bcls_pkg::DEF_NUM_BINS];
    logic signed [31:0] thr_mem [bcls_pkg::TABLE_STAGES];
    bit                 thr_set [bcls_pkg::TABLE_STAGES];
    logic signed [31:0] run_score = '0;
    int unsigned        stage_ptr = 0;
    logic [31:0]        win_dev = '0;
    t_win_state         win_state = WIN_IDLE;
    logic [8:0]         cfg_stages = bcls_pkg::STAGES_RESET;
    logic               cfg_gate = 1'b1;
    logic [31:0]        cfg_dev_thr = '0;

    bcls_pkg::t_res pending_decisions [$];

    int beats_sent = 0;
    int decisions_seen = 0;
    int faces_seen = 0;
    int settings_used = 0;
    int mismatches = 0;
    int quiet_cycles = 0;
    int sender_calm = 0;
    int sink_calm = 0;

    initial begin
        forever #1 clk = ~clk;
    end

    // ------------------------------------------------------------------
    // Prediction
    // ------------------------------------------------------------------
    function automatic int unsigned usable_stages();
        int unsigned n;
        n = 32'(cfg_stages);
        if (n > bcls_pkg::DEF_MAX_STAGES) n = bcls_pkg::DEF_MAX_STAGES;
        if (n > bcls_pkg::TABLE_STAGES) n = bcls_pkg::TABLE_STAGES;
        return n - n % bcls_pkg::DEF_GROUP_SIZE;
    endfunction

    function automatic logic signed [31:0] sat_add(logic signed [31:0] a,
                                                   logic signed [15:0] w);
        longint t;
        t = longint'(a) + longint'(w);
        if (t > SCORE_MAX) t = SCORE_MAX;
        if (t < SCORE_MIN) t = SCORE_MIN;
        return 32'(t);
    endfunction

    function automatic void close_window(bit passed);
        bcls_pkg::t_res d;
        d.face  = passed && (!cfg_gate || win_dev > cfg_dev_thr);
        d.score = run_score;
        d.count = 9'(stage_ptr);
        pending_decisions.insert(pending_decisions.size(), d);
        win_state = WIN_DONE;
    endfunction

    function automatic void predict_beat(t_scorer_cmd b);
        int s;
        int f;
        case (b.cmd)
            bcls_pkg::CMD_WEIGHT: begin
                if (b.stage < bcls_pkg::DEF_MAX_STAGES && b.bin < bcls_pkg::DEF_NUM_BINS) begin
                    weight_mem[b.stage][b.bin] = b.weight;
                    weight_set[b.stage][b.bin] = 1'b1;
                end
            end
            bcls_pkg::CMD_THRESHOLD: begin
                if (b.stage < bcls_pkg::DEF_MAX_STAGES) begin
                    thr_mem[b.stage] = b.thr;
                    thr_set[b.stage] = 1'b1;
                end
            end
            bcls_pkg::CMD_START: begin
                run_score = '0;
                stage_ptr = 0;
                win_dev   = b.dev;
                win_state = WIN_ACTIVE;
                if (usable_stages() == 0) close_window(1'b1);
            end
            bcls_pkg::CMD_FEATURE: begin
                if (win_state == WIN_ACTIVE) begin
                    f = int'(b.feat);
                    if (f >= bcls_pkg::DEF_NUM_BINS) f = bcls_pkg::DEF_NUM_BINS - 1;
                    s = int'(stage_ptr % bcls_pkg::TABLE_STAGES);
                    run_score = sat_add(run_score, weight_mem[s][f]);
                    stage_ptr++;
                    // group check first, then the end of the cascade
                    if (stage_ptr % bcls_pkg::DEF_GROUP_SIZE == 0 && run_score < thr_mem[s])
                        close_window(1'b0);
                    else if (stage_ptr >= usable_stages())
                        close_window(1'b1);
                end
            end
            default: begin
            end
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Random picks
    // ------------------------------------------------------------------
    function automatic int pick_gap(inout int calm_left);
        int r;
        if (calm_left > 0) begin
            calm_left--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 3) begin
            calm_left = $urandom_range(10, 40);
            return 0;
        end
        if (r < 55) return 0;
        if (r < 85) return $urandom_range(1, 3);
        if (r < 97) return $urandom_range(4, 10);
        return $urandom_range(20, 40);
    endfunction

    function automatic t_scorer_cmd random_beat(bcls_pkg::t_cmd c);
        t_scorer_cmd b;
        b.cmd    = c;
        b.stage  = 8'($urandom);
        b.bin    = 8'($urandom);
        b.weight = 16'($urandom);
        b.thr    = $urandom;
        b.dev    = $urandom;
        b.feat   = 8'($urandom);
        return b;
    endfunction

    function automatic logic [7:0] pick_feature();
        case ($urandom_range(0, 9))
            0: return 8'h00;
            1: return 8'hFF;
            default: return 8'($urandom);
        endcase
    endfunction

    function automatic logic signed [15:0] pick_weight();
        case ($urandom_range(0, 9))
            0: return 16'sh7FFF;
            1: return 16'sh8000;
            2, 3: return 16'($urandom);
            default: return 16'(int'($urandom_range(0, 1024)) - 512);
        endcase
    endfunction

    function automatic logic [31:0] pick_deviation();
        case ($urandom_range(0, 7))
            0: return cfg_dev_thr;
            1: return cfg_dev_thr + 32'd1;
            2: return cfg_dev_thr - 32'd1;
            3: return 32'd0;
            4: return 32'hFFFF_FFFF;
            default: return $urandom;
        endcase
    endfunction

    // Threshold for a group end: at or below the coming score to pass, above to fail.
    function automatic logic signed [31:0] pick_threshold(logic signed [31:0] after,
                                                          bit fail);
        longint t;
        longint delta;
        int r;
        r = $urandom_range(0, 9);
        if (r == 9) begin
            t = fail ? SCORE_MAX : SCORE_MIN;
        end else if (r < 3) begin
            t = fail ? longint'(after) + 1 : longint'(after);
        end else begin
            delta = longint'($urandom_range(1, 5000));
            t = fail ? longint'(after) + delta : longint'(after) - delta;
        end
        if (t > SCORE_MAX) t = SCORE_MAX;
        if (t < SCORE_MIN) t = SCORE_MIN;
        return 32'(t);
    endfunction

    // ------------------------------------------------------------------
    // Drivers
    // ------------------------------------------------------------------
    task automatic send_beat(t_scorer_cmd b);
        int gap;
        gap = pick_gap(sender_calm);
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        in_command <= b.cmd;
        in_stage   <= b.stage;
        in_bin     <= b.bin;
        in_weight  <= b.weight;
        in_thr     <= b.thr;
        in_dev     <= b.dev;
        in_feat    <= b.feat;
        in_valid   <= 1'b1;
        @(posedge clk);
        while (!o_in_ready) @(posedge clk);
        predict_beat(b);
        beats_sent++;
    endtask

    // Hold off until every decision is out and the pipeline has drained.
    task automatic settle();
        in_valid <= 1'b0;
        while (pending_decisions.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic write_reg(bcls_pkg::t_cfg_reg idx, logic [31:0] value);
        settle();
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!o_cfg_ready) @(posedge clk);
        case (idx)
            bcls_pkg::CFG_STAGES:  cfg_stages  = value[8:0];
            bcls_pkg::CFG_GATE_EN: cfg_gate    = value[0];
            bcls_pkg::CFG_DEV_THR: cfg_dev_thr = value;
            default: ;
        endcase
        cfg_valid <= 1'b0;
    endtask

    // Feed the next stage of the active window, loading any table entry it needs.
    task automatic send_feature(int fail_pct);
        t_scorer_cmd b;
        logic [7:0] f;
        int s;
        logic signed [31:0] after;
        f = pick_feature();
        s = int'(stage_ptr % bcls_pkg::TABLE_STAGES);
        if (!weight_set[s][f] || $urandom_range(0, 4) == 0) begin
            b = random_beat(bcls_pkg::CMD_WEIGHT);
            b.stage  = 8'(s);
            b.bin    = f;
            b.weight = pick_weight();
            send_beat(b);
        end
        if ((stage_ptr + 1) % bcls_pkg::DEF_GROUP_SIZE == 0 &&
            (!thr_set[s] || fail_pct == 0 || $urandom_range(0, 99) < 70)) begin
            after = sat_add(run_score, weight_mem[s][f]);
            b = random_beat(bcls_pkg::CMD_THRESHOLD);
            b.stage = 8'(s);
            b.thr   = pick_threshold(after, $urandom_range(0, 99) < fail_pct);
            send_beat(b);
        end
        b = random_beat(bcls_pkg::CMD_FEATURE);
        b.feat = f;
        send_beat(b);
    endtask

    task automatic run_window(int feat_budget, int fail_pct);
        t_scorer_cmd b;
        int n;
        b = random_beat(bcls_pkg::CMD_START);
        b.dev = pick_deviation();
        send_beat(b);
        n = 0;
        while (win_state == WIN_ACTIVE && n < feat_budget && beats_sent < ITEM_TARGET) begin
            send_feature(fail_pct);
            n++;
        end
        // stray feature after the decision: dropped
        if (win_state != WIN_ACTIVE && $urandom_range(0, 6) == 0)
            send_beat(random_beat(bcls_pkg::CMD_FEATURE));
    endtask

    task automatic send_noise();
        case ($urandom_range(0, 2))
            0: send_beat(random_beat(bcls_pkg::CMD_WEIGHT));
            1: send_beat(random_beat(bcls_pkg::CMD_THRESHOLD));
            default: begin
                if (win_state == WIN_ACTIVE) send_feature($urandom_range(0, 30));
                else send_beat(random_beat(bcls_pkg::CMD_FEATURE));
            end
        endcase
    endtask

    task automatic choose_setting();
        int r;
        logic [8:0] n;
        logic [31:0] upper;
        logic [31:0] thr;
        r = $urandom_range(0, 99);
        if (r < 45) n = 9'($urandom_range(10, 60));
        else if (r < 55) n = 9'($urandom_range(0, 9));
        else if (r < 62) n = bcls_pkg::STAGES_RESET;
        else if (r < 70) n = 9'($urandom_range(250, 255));
        else if (r < 76) n = 9'($urandom_range(256, 511));
        else n = 9'($urandom_range(0, 511));
        upper = $urandom_range(0, 1) ? $urandom : 32'd0;
        write_reg(bcls_pkg::CFG_STAGES, {upper[31:9], n});
        upper = $urandom_range(0, 1) ? $urandom : 32'd0;
        write_reg(bcls_pkg::CFG_GATE_EN, {upper[31:1], 1'($urandom_range(0, 1))});
        case ($urandom_range(0, 3))
            0: thr = 32'd0;
            1: thr = 32'hFFFF_FFFF;
            default: thr = $urandom;
        endcase
        write_reg(bcls_pkg::CFG_DEV_THR, thr);
        settings_used++;
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_idle_features();
        repeat (2) send_beat(random_beat(bcls_pkg::CMD_FEATURE));
    endtask

    task automatic test_empty_cascade();
        t_scorer_cmd b;
        write_reg(bcls_pkg::CFG_STAGES, 32'd0);
        write_reg(bcls_pkg::CFG_GATE_EN, 32'd1);
        write_reg(bcls_pkg::CFG_DEV_THR, 32'h0001_8000);
        b = random_beat(bcls_pkg::CMD_START);
        b.dev = 32'h0001_8000;
        send_beat(b);
        b.dev = 32'h0001_8001;
        send_beat(b);
        b.dev = 32'hFFFF_FFFF;
        send_beat(b);
        send_beat(random_beat(bcls_pkg::CMD_FEATURE));
        // a count below one group rounds down to none
        write_reg(bcls_pkg::CFG_STAGES, 32'd9);
        write_reg(bcls_pkg::CFG_GATE_EN, 32'd0);
        b.dev = 32'd0;
        send_beat(b);
        settings_used++;
    endtask

    // One group with extreme weights, the threshold exactly at the final score.
    task automatic test_single_group();
        t_scorer_cmd b;
        logic [7:0] f;
        int i;
        write_reg(bcls_pkg::CFG_STAGES, 32'd10);
        write_reg(bcls_pkg::CFG_GATE_EN, 32'd0);
        send_beat(random_beat(bcls_pkg::CMD_START));
        for (i = 0; i < bcls_pkg::DEF_GROUP_SIZE; i++) begin
            f = (i % 2) ? 8'hFF : 8'h00;
            b = random_beat(bcls_pkg::CMD_WEIGHT);
            b.stage = 8'(i);
            b.bin   = f;
            b.weight = (i % 3 == 0) ? 16'sh7FFF : (i % 3 == 1) ? 16'sh8000 : 16'sh0155;
            send_beat(b);
            if (i == bcls_pkg::DEF_GROUP_SIZE - 1) begin
                b = random_beat(bcls_pkg::CMD_THRESHOLD);
                b.stage = 8'(i);
                b.thr   = sat_add(run_score, weight_mem[i][f]);
                send_beat(b);
            end
            b = random_beat(bcls_pkg::CMD_FEATURE);
            b.feat = f;
            send_beat(b);
        end
        send_beat(random_beat(bcls_pkg::CMD_FEATURE));
        settings_used++;
    endtask

    task automatic test_lowered_count();
        write_reg(bcls_pkg::CFG_STAGES, 32'd30);
        write_reg(bcls_pkg::CFG_GATE_EN, 32'd0);
        send_beat(random_beat(bcls_pkg::CMD_START));
        repeat (3) send_feature(0);
        // restart drops the partial window without a decision
        run_window(12, 0);
        write_reg(bcls_pkg::CFG_STAGES, 32'd10);
        send_feature(0);
        write_reg(bcls_pkg::CFG_STAGES, 32'd20);
        run_window(3, 0);
        write_reg(bcls_pkg::CFG_STAGES, 32'd0);
        send_feature(0);
        settings_used += 3;
    endtask

    task automatic test_random_traffic();
        int r;
        while (beats_sent < ITEM_TARGET) begin
            choose_setting();
            repeat ($urandom_range(3, 10)) begin
                if (beats_sent < ITEM_TARGET) begin
                    r = $urandom_range(0, 99);
                    if (r < 75) begin
                        run_window(($urandom_range(0, 9) == 0) ? $urandom_range(1, 25) : 1000,
                                   $urandom_range(0, 30));
                    end else begin
                        send_noise();
                    end
                end
            end
        end
    endtask

    // ------------------------------------------------------------------
    // Result side
    // ------------------------------------------------------------------
    task automatic report_mismatch(string msg);
        mismatches++;
        if (mismatches <= MAX_REPORTS) $display("[%0t] mismatch: %s", $time, msg);
    endtask

    initial begin : result_sink
        int hold;
        hold = 0;
        forever begin
            @(posedge clk);
            if (hold > 0) begin
                hold--;
            end else if (out_ready) begin
                hold = pick_gap(sink_calm);
                if (hold > 0) out_ready <= 1'b0;
            end else begin
                out_ready <= 1'b1;
            end
        end
    end

    always @(posedge clk) begin : check_decision
        bcls_pkg::t_res want;
        if (rst_n && o_out_valid && out_ready) begin
            if (pending_decisions.size() == 0) begin
                report_mismatch("decision with none pending");
            end else begin
                want = pending_decisions.pop_front();
                decisions_seen++;
                if (o_is_face === 1'b1) faces_seen++;
                if (o_is_face !== want.face)
                    report_mismatch($sformatf("decision %0d is_face %b, want %b",
                                              decisions_seen, o_is_face, want.face));
                if (o_score !== want.score)
                    report_mismatch($sformatf("decision %0d score %0d, want %0d",
                                              decisions_seen, o_score, want.score));
                if (o_stages_done !== want.count)
                    report_mismatch($sformatf("decision %0d stages_done %0d, want %0d",
                                              decisions_seen, o_stages_done, want.count));
            end
        end
    end

    // End the run if no channel moves a beat for too long.
    always @(posedge clk) begin
        if (!rst_n || (in_valid && o_in_ready) || (o_out_valid && out_ready) ||
            (cfg_valid && o_cfg_ready))
            quiet_cycles <= 0;
        else
            quiet_cycles <= quiet_cycles + 1;
        if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no beat for %0d cycles", quiet_cycles);
            $display("Some tests failed");
            $finish;
        end
    end

    initial begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_idle_features();
        test_empty_cascade();
        test_single_group();
        test_lowered_count();
        test_random_traffic();
        settle();
        $display("Sent %0d command beats over %0d register settings; checked %0d decisions",
                 beats_sent, settings_used, decisions_seen);
        $display("Windows accepted: %0d, rejected or gated: %0d, mismatches: %0d",
                 faces_seen, decisions_seen - faces_seen, mismatches);
        if (mismatches == 0) begin
            $display("All tests passed");
        end else begin
            $display("Some tests failed");
        end
        $finish;
    end

endmodule

FILE: boosted_cascade_lut_scorer.f
+incdir+sv
sv/bcls_pkg.sv
sv/bcls_ram.sv
sv/bcls_front.sv
sv/bcls_score.sv
sv/boosted_cascade_lut_scorer.sv
bench/tb.sv
